/* design/plbb_pkg.sv */
// ----------------------------------------------------------------------------
// plbb_pkg
// shared types and constants of the packed lcd bitmap blitter
// ----------------------------------------------------------------------------
package plbb_pkg;

    localparam logic [2:0] ACT_PIXEL = 3'd0;
    localparam logic [2:0] ACT_RECT  = 3'd1;
    localparam logic [2:0] ACT_BOX   = 3'd2;
    localparam logic [2:0] ACT_BYTE  = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;

    // phase masks: three pixels share a byte pair
    localparam logic [7:0] MASK_P0_FIRST  = 8'hE0;
    localparam logic [7:0] MASK_P0_SECOND = 8'h07;
    localparam logic [7:0] MASK_P1_FIRST  = 8'h1F;
    localparam logic [7:0] MASK_P2_SECOND = 8'hF8;

    // reciprocal of three for values below 512
    localparam logic [8:0] RECIP3 = 9'd171;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] span_w;
        logic [7:0] span_h;
        logic       pixel_on;
        logic       invert;
        logic [3:0] bits_per_byte;
        logic [7:0] bitmap_byte;
        logic [6:0] mem_column;
    } plbb_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } plbb_out_t;

    typedef struct packed {
        logic load;
        logic sweep_init;
        logic sweep_wr;
        logic rect_init;
        logic rect_pick;
        logic rect_step;
        logic box_load;
        logic bmp_init;
        logic bmp_pick;
        logic bmp_step;
        logic single_pick;
        logic div;
        logic addr;
        logic rd_addr;
        logic mem_rd;
        logic wr0;
        logic wr1;
        logic clip_set;
        logic rd_cap;
        logic out_load;
    } plbb_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       sweep_last;
        logic       rect_empty;
        logic       rect_done;
        logic       bmp_done;
        logic       offscreen;
    } plbb_status_t;

endpackage

/* design/plbb_ctrl.sv */
// ----------------------------------------------------------------------------
// plbb_ctrl
// sequencer: clearing sweep, action dispatch and per-pixel read-modify-write
// ----------------------------------------------------------------------------
module plbb_ctrl
    import plbb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  plbb_status_t status,
    output plbb_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_DISPATCH, S_RECT_PICK, S_BMP_PICK, S_DIV, S_ADDR,
        S_READ, S_WR0, S_WR1, S_STEP, S_RD_WAIT, S_RD_CAP, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        M_SINGLE, M_RECT, M_BMP, M_CLEAR
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = (mode_reg == M_CLEAR) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.action)
                    ACT_PIXEL:
                    begin
                        cmd.single_pick = 1'b1;
                        mode_next       = M_SINGLE;
                        state_next      = S_DIV;
                    end
                    ACT_RECT:
                    begin
                        cmd.rect_init = 1'b1;
                        mode_next     = M_RECT;
                        state_next    = status.rect_empty ? S_DONE : S_RECT_PICK;
                    end
                    ACT_BOX:
                    begin
                        cmd.box_load = 1'b1;
                        state_next   = S_DONE;
                    end
                    ACT_BYTE:
                    begin
                        cmd.bmp_init = 1'b1;
                        mode_next    = M_BMP;
                        state_next   = S_BMP_PICK;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.sweep_init = 1'b1;
                        mode_next      = M_CLEAR;
                        state_next     = S_SWEEP;
                    end
                    ACT_READ:
                    begin
                        cmd.rd_addr = 1'b1;
                        state_next  = S_RD_WAIT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RECT_PICK:
            begin
                if (status.rect_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rect_pick = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_BMP_PICK:
            begin
                if (status.bmp_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.bmp_pick = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.offscreen)
                begin
                    cmd.clip_set = 1'b1;
                    state_next   = S_STEP;
                end
                else
                begin
                    cmd.div    = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_WR0;
            end
            S_WR0:
            begin
                cmd.wr0    = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.wr1    = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                priority case (mode_reg)
                    M_RECT:
                    begin
                        cmd.rect_step = 1'b1;
                        state_next    = S_RECT_PICK;
                    end
                    M_BMP:
                    begin
                        cmd.bmp_step = 1'b1;
                        state_next   = S_BMP_PICK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                cmd.rd_cap = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            mode_reg      <= M_SINGLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/plbb_datapath.sv */
// ----------------------------------------------------------------------------
// plbb_datapath
// frame store, pixel address unit, rectangle and bitmap walkers
// ----------------------------------------------------------------------------
module plbb_datapath
    import plbb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 160
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  plbb_in_t     in_item,
    input  plbb_cmd_t    cmd,
    output plbb_status_t status,
    output plbb_out_t    out_item
);

    localparam int FRAME_COLS = 2 * ((SCREEN_WIDTH + 2) / 3);
    localparam int FRAME_SIZE = FRAME_COLS * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(FRAME_SIZE);
    localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] PAIR_STEP = ADDR_W'(2 * SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(FRAME_SIZE - 1);
    localparam logic [7:0] COLS8 = 8'(FRAME_COLS);

    logic [7:0] mem [FRAME_SIZE];

    plbb_in_t        item_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] addr0_reg, addr1_reg;
    logic [7:0]      rd0_reg, rd1_reg;
    logic [7:0]      m0_reg, m1_reg;
    logic [8:0]      pix_x_reg, pix_y_reg;
    logic            pix_on_reg;
    logic [7:0]      q_reg;
    logic [1:0]      r_reg;
    logic            clip_reg, rd_zero_reg;
    logic [7:0]      rd_reg;
    logic [8:0]      ix_reg, iy_reg, xe_reg, ye_reg;
    logic [7:0]      box_ox_reg, box_oy_reg, box_w_reg, box_h_reg;
    logic [7:0]      cur_x_reg, cur_y_reg;
    logic [3:0]      box_bits_reg, bit_cnt_reg;
    logic            box_inv_reg, box_src_reg;
    plbb_out_t       out_reg;

    logic [17:0] prod3;
    logic [7:0]  q0;
    logic [8:0]  rem;
    logic [3:0]  bit_sel;
    logic        bmp_bit;
    logic [8:0]  cur_x_inc;

    assign prod3   = pix_x_reg * RECIP3;
    assign q0      = prod3[16:9];
    assign rem     = pix_x_reg - 9'(q0) * 9'd3;
    assign bit_sel = box_bits_reg - 4'd1 - bit_cnt_reg;
    assign bmp_bit = (box_src_reg && item_reg.bitmap_byte[bit_sel[2:0]]) ^ box_inv_reg;
    assign cur_x_inc = {1'b0, cur_x_reg} + 9'd1;

    assign status.action     = item_reg.action;
    assign status.sweep_last = (sweep_reg == SWEEP_END);
    assign status.rect_empty = (item_reg.span_w == 8'd0) || (item_reg.span_h == 8'd0);
    assign status.rect_done  = (ix_reg >= xe_reg) || ({1'b0, item_reg.pos_y} >= ye_reg);
    assign status.bmp_done   = (bit_cnt_reg >= box_bits_reg) || (box_w_reg == 8'd0)
                               || (cur_y_reg >= box_h_reg);
    assign status.offscreen  = (pix_x_reg >= W9) || (pix_y_reg >= H9);

    // frame store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr)
        begin
            mem[sweep_reg] <= 8'd0;
        end
        else if (cmd.wr0)
        begin
            mem[addr0_reg] <= pix_on_reg ? (rd0_reg | m0_reg) : (rd0_reg & ~m0_reg);
        end
        else if (cmd.wr1)
        begin
            mem[addr1_reg] <= pix_on_reg ? (rd1_reg | m1_reg) : (rd1_reg & ~m1_reg);
        end
        if (cmd.mem_rd)
        begin
            rd0_reg <= mem[addr0_reg];
            rd1_reg <= mem[addr1_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.single_pick)
        begin
            pix_x_reg  <= {1'b0, item_reg.pos_x};
            pix_y_reg  <= {1'b0, item_reg.pos_y};
            pix_on_reg <= item_reg.pixel_on;
        end
        else if (cmd.rect_pick)
        begin
            pix_x_reg  <= ix_reg;
            pix_y_reg  <= iy_reg;
            pix_on_reg <= item_reg.pixel_on;
        end
        else if (cmd.bmp_pick)
        begin
            pix_x_reg  <= {1'b0, box_ox_reg} + {1'b0, cur_x_reg};
            pix_y_reg  <= {1'b0, box_oy_reg} + {1'b0, cur_y_reg};
            pix_on_reg <= bmp_bit;
        end
        if (cmd.div)
        begin
            q_reg <= q0;
            r_reg <= rem[1:0];
        end
        if (cmd.addr)
        begin
            addr0_reg <= ADDR_W'(q_reg) * PAIR_STEP + ADDR_W'(pix_y_reg);
            addr1_reg <= ADDR_W'(q_reg) * PAIR_STEP + ADDR_W'(pix_y_reg) + ROW_STEP;
            unique case (r_reg)
                2'd0:
                begin
                    m0_reg <= MASK_P0_FIRST;
                    m1_reg <= MASK_P0_SECOND;
                end
                2'd1:
                begin
                    m0_reg <= MASK_P1_FIRST;
                    m1_reg <= 8'd0;
                end
                default:
                begin
                    m0_reg <= 8'd0;
                    m1_reg <= MASK_P2_SECOND;
                end
            endcase
        end
        else if (cmd.rd_addr)
        begin
            addr0_reg   <= ADDR_W'(item_reg.mem_column) * ROW_STEP + ADDR_W'(item_reg.pos_y);
            addr1_reg   <= ADDR_W'(item_reg.mem_column) * ROW_STEP + ADDR_W'(item_reg.pos_y);
            rd_zero_reg <= ({1'b0, item_reg.mem_column} >= COLS8)
                           || ({1'b0, item_reg.pos_y} >= H9);
        end
        if (cmd.rect_init)
        begin
            ix_reg <= {1'b0, item_reg.pos_x};
            iy_reg <= {1'b0, item_reg.pos_y};
        end
        else if (cmd.rect_step)
        begin
            if (iy_reg + 9'd1 >= ye_reg)
            begin
                iy_reg <= {1'b0, item_reg.pos_y};
                ix_reg <= ix_reg + 9'd1;
            end
            else
            begin
                iy_reg <= iy_reg + 9'd1;
            end
        end
        if (cmd.rd_cap)
        begin
            rd_reg <= rd_zero_reg ? 8'd0 : rd0_reg;
        end
        if (cmd.out_load)
        begin
            out_reg.read_data <= (item_reg.action == ACT_READ) ? rd_reg : 8'd0;
            out_reg.clipped   <= clip_reg;
        end
    end

    // rectangle ends are computed from the held item
    logic [8:0] rx_end, ry_end;
    assign rx_end = {1'b0, item_reg.pos_x} + {1'b0, item_reg.span_w};
    assign ry_end = {1'b0, item_reg.pos_y} + {1'b0, item_reg.span_h};

    always_ff @(posedge clk)
    begin
        if (cmd.rect_init)
        begin
            xe_reg <= (rx_end > W9) ? W9 : rx_end;
            ye_reg <= (ry_end > H9) ? H9 : ry_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg    <= '0;
            clip_reg     <= 1'b0;
            box_ox_reg   <= 8'd0;
            box_oy_reg   <= 8'd0;
            box_w_reg    <= 8'd0;
            box_h_reg    <= 8'd0;
            cur_x_reg    <= 8'd0;
            cur_y_reg    <= 8'd0;
            box_bits_reg <= 4'd8;
            box_inv_reg  <= 1'b0;
            box_src_reg  <= 1'b1;
            bit_cnt_reg  <= 4'd0;
        end
        else
        begin
            if (cmd.sweep_init)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_wr && !status.sweep_last)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            if (cmd.load)
            begin
                clip_reg <= 1'b0;
            end
            else if (cmd.rect_init)
            begin
                clip_reg <= !status.rect_empty && ((rx_end > W9) || (ry_end > H9));
            end
            else if (cmd.clip_set)
            begin
                clip_reg <= 1'b1;
            end
            if (cmd.box_load)
            begin
                box_ox_reg   <= item_reg.pos_x;
                box_oy_reg   <= item_reg.pos_y;
                box_w_reg    <= item_reg.span_w;
                box_h_reg    <= item_reg.span_h;
                cur_x_reg    <= 8'd0;
                cur_y_reg    <= 8'd0;
                box_bits_reg <= (item_reg.bits_per_byte == 4'd0 || item_reg.bits_per_byte > 4'd8)
                                ? 4'd8 : item_reg.bits_per_byte;
                box_inv_reg  <= item_reg.invert;
                box_src_reg  <= item_reg.pixel_on;
            end
            if (cmd.bmp_init)
            begin
                bit_cnt_reg <= 4'd0;
            end
            else if (cmd.bmp_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + 4'd1;
                if (cur_x_inc >= {1'b0, box_w_reg})
                begin
                    cur_x_reg <= 8'd0;
                    cur_y_reg <= cur_y_reg + 8'd1;
                end
                else
                begin
                    cur_x_reg <= cur_x_inc[7:0];
                end
            end
        end
    end

    assign out_item = out_reg;

endmodule

/* design/packed_lcd_bitmap_blitter.sv */
// ----------------------------------------------------------------------------
// packed_lcd_bitmap_blitter
// drawing engine for a packed monochrome frame store, three pixels per byte pair
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_item) takes one drawing action per item;
//   out channel (out_valid/out_ready/out_item) returns one result per item
//   with read_data and clipped
//   one item is worked on at a time; in_ready is high while the engine idles
//   every drawn pixel is a read-modify-write of a byte pair through the
//   single write port of the frame store; an off-screen pixel, in a bitmap
//   byte or alone, skips that and only sets clipped; clear all sweeps the
//   whole frame store one byte per cycle
//   after reset the same sweep clears the frame store, in_ready low meanwhile
//   the result sits in an output register: the next item is accepted while it
//   waits; if the receiver stalls, the following item waits at its end
// ----------------------------------------------------------------------------
module packed_lcd_bitmap_blitter
    import plbb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 160
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  plbb_in_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output plbb_out_t out_item
);

    // command and status between sequencer and datapath
    plbb_cmd_t    cmd;
    plbb_status_t status;

    plbb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    plbb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

`ifndef NO_ASSERTIONS
    // one item at a time: an accept is followed by a busy cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // read data and clip flag never come from the same action
    a_read_noclip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.read_data != 8'd0) |-> !out_item.clipped)
        else $error("read result flagged clipped");
`endif

endmodule
